// ===== hw/rtl/midi_mono_cv_voice_macros.svh =====
// Assertion macros shared by the voice RTL.
`ifndef MIDI_MONO_CV_VOICE_MACROS_SVH
`define MIDI_MONO_CV_VOICE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define MCV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define MCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mcv_pkg.sv =====
// Types, codes and constants of the MIDI-to-CV voice.
package mcv_pkg;

    // USB MIDI code index values
    localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
    localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
    localparam logic [3:0] CIN_CTRL     = 4'hB;
    localparam logic [3:0] CIN_PRESSURE = 4'hD;
    localparam logic [3:0] CIN_BEND     = 4'hE;

    // Controller numbers
    localparam logic [6:0] CC_MOD_MSB    = 7'd1;
    localparam logic [6:0] CC_MOD_LSB    = 7'd33;
    localparam logic [6:0] CC_BREATH_MSB = 7'd2;
    localparam logic [6:0] CC_BREATH_LSB = 7'd34;
    localparam logic [6:0] CC_BEND_RANGE = 7'd3;
    localparam logic [6:0] CC_PORTA_MSB  = 7'd5;
    localparam logic [6:0] CC_PORTA_LSB  = 7'd37;
    localparam logic [6:0] CC_DAMPER     = 7'd64;
    localparam logic [6:0] CC_SOUND_OFF  = 7'd120;
    localparam logic [6:0] CC_NOTES_OFF  = 7'd123;
    localparam logic [6:0] CC_MONO       = 7'd126;
    localparam logic [6:0] CC_POLY       = 7'd127;

    // Configuration register indexes
    localparam logic CFG_CHANNEL = 1'b0;
    localparam logic CFG_RETRIG  = 1'b1;

    // Arithmetic constants
    localparam logic [15:0] GLIDE_SCALE    = 16'd55040;
    localparam logic [14:0] BEND_CENTER    = 15'h2000;
    localparam logic [15:0] LOW_KEEP       = 16'h01FF;
    localparam logic [15:0] HIGH_KEEP      = 16'hFE00;
    localparam logic [15:0] BEND_RANGE_RST = 16'd6144;
    localparam logic [15:0] COEF_RST       = 16'hFFFF;

    // One held note
    typedef struct packed {
        logic [6:0] note;
        logic [6:0] vel;
    } stk_entry_t;

    // Note stack commands
    typedef struct packed {
        logic push;
        logic remove;
    } stk_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_REMOVE,
        ST_OFF_FIN,
        ST_PORTA_MUL,
        ST_PORTA_FIN,
        ST_BEND_MUL,
        ST_BEND_FIN,
        ST_GLIDE_P,
        ST_GLIDE_V,
        ST_GLIDE_VW,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/mcv_mul.sv =====
// Shared signed multiplier with registered product.
module mcv_mul (
    input  logic               clk,
    input  logic signed [17:0] a,
    input  logic signed [16:0] b,
    output logic signed [34:0] p
);
    logic signed [34:0] p_reg;

    // Register the product
    always_ff @(posedge clk)
    begin
        p_reg <= 35'(a) * 35'(b);
    end

    assign p = p_reg;
endmodule

// ===== hw/rtl/mcv_stack.sv =====
// Last-note-priority note stack held in a shift line.
module mcv_stack #(
    parameter int STACK_DEPTH = 8,
    parameter int IDX_W       = 3
) (
    input  logic               clk,
    input  mcv_pkg::stk_cmd_t  cmd,
    input  logic [IDX_W-1:0]   idx,
    input  mcv_pkg::stk_entry_t wr_entry,
    output logic [6:0]         rd_note,
    output mcv_pkg::stk_entry_t top
);
    import mcv_pkg::*;

    stk_entry_t ent_reg [STACK_DEPTH];

    // Push at the top or close the gap at idx
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            if (cmd.push)
            begin
                if (i == 0)
                    ent_reg[i] <= wr_entry;
                else
                    ent_reg[i] <= ent_reg[i-1];
            end
            else if (cmd.remove && (i < STACK_DEPTH - 1) && (IDX_W'(i) >= idx))
            begin
                ent_reg[i] <= ent_reg[(i < STACK_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign rd_note = ent_reg[idx].note;
    assign top     = ent_reg[0];
endmodule

// ===== hw/rtl/midi_mono_cv_voice.sv =====
// Monophonic MIDI-to-CV voice: sequencer, state and output register.
//
// Usage: slave stream carries one request per beat, s_tuser = 1 for a control
// tick and 0 for a MIDI message. Messages on the configured channel update the
// note stack and controllers and give no result; each tick advances the
// pitch and velocity glide and gives one result beat on the master stream.
// The block takes one request at a time (s_tready low while busy).
// Note-off searches the note stack one entry a cycle. All products go through
// one shared multiplier with a registered output.
// A finished tick result waits in the output register until m_tready; a later
// tick holds in the emit step meanwhile, so no result is lost.
// Reset clears all control and voice state: no notes held, bend range one
// octave, glide coefficient full scale, controllers zero. Configuration must
// be written through cfg_we/cfg_addr/cfg_data while the block is idle; the
// block itself does not enforce this.
module midi_mono_cv_voice #(
    parameter int STACK_DEPTH     = 8,
    parameter int RETRIGGER_TICKS = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // code_index, message_channel, data_byte_one, data_byte_two
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pitch_cv, velocity_cv, last_velocity_cv, modwheel_cv,
                                   // breath_cv, aftertouch_cv
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_data
);
    import mcv_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C     = CNT_W'(STACK_DEPTH);
    localparam logic [1:0]       RETRIG_LOAD = 2'(RETRIGGER_TICKS);

    state_t state_reg, state_next;

    // Latched request
    logic       act_reg;
    logic [3:0] code_reg;
    logic [3:0] chan_reg;
    logic [6:0] b1_reg;
    logic [6:0] b2_reg;

    // Configuration
    logic [3:0] midi_chan_reg;
    logic       retrig_en_reg;

    // Voice state
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] sidx_reg, sidx_next;
    logic [31:0] pt_reg, pt_next, pc_reg, pc_next;
    logic [31:0] vt_reg, vt_next, vc_reg, vc_next;
    logic [6:0]  lvel_reg, lvel_next;
    logic [15:0] brange_reg, brange_next;
    logic [16:0] boff_reg, boff_next;
    logic [15:0] coef_reg, coef_next;
    logic [15:0] porta_reg, porta_next;
    logic        damper_reg, damper_next;
    logic        poly_reg, poly_next;
    logic [1:0]  rleft_reg, rleft_next;
    logic [15:0] mod_reg, mod_next, breath_reg, breath_next, at_reg, at_next;

    // Output register
    logic        mvalid_reg, mvalid_next;
    logic [95:0] mdata_reg, mdata_next;

    // Shared multiplier and stack
    logic signed [17:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [34:0] mul_p;
    stk_cmd_t   stk_cmd;
    stk_entry_t stk_wr, stk_top;
    logic [6:0] stk_rd_note;

    mcv_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    mcv_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .IDX_W       (IDX_W)
    ) u_stack (
        .clk      (clk),
        .cmd      (stk_cmd),
        .idx      (sidx_reg[IDX_W-1:0]),
        .wr_entry (stk_wr),
        .rd_note  (stk_rd_note),
        .top      (stk_top)
    );

    // Datapath helpers
    logic signed [32:0] gdiff;
    logic signed [16:0] gstep;
    logic [31:0]        gcur, ggoal;
    logic [27:0]        exp_sh;
    logic [16:0]        exp_sum;
    logic [15:0]        exp_arg;
    logic signed [21:0] bq;
    logic signed [16:0] pq, vq;
    logic signed [17:0] psum;
    logic [CNT_W-1:0]   held_inc;

    always_comb
    begin
        // Glide step: (goal - cur) / 65536 truncated towards zero
        gcur  = (state_reg == ST_GLIDE_P) ? pc_reg : vc_reg;
        ggoal = (state_reg == ST_GLIDE_P) ? pt_reg : vt_reg;
        gdiff = $signed({ggoal[31], ggoal}) - $signed({gcur[31], gcur});
        gstep = 17'(gdiff >>> 16) + 17'((gdiff[32] && (gdiff[15:0] != 16'd0)) ? 1 : 0);
        // Fast exp2 of the portamento argument
        exp_arg = ~mul_p[31:16];
        exp_sh  = 28'({exp_arg[11:0], 12'd0} >> 12) << exp_arg[15:12];
        exp_sum = 17'(17'd1 << exp_arg[15:12]) + {1'b0, exp_sh[27:12]};
        // Bend product / 8192 truncated towards zero
        bq = 22'(mul_p >>> 13) + 22'((mul_p[34] && (mul_p[12:0] != 13'd0)) ? 1 : 0);
        // Outputs: current / 32768 truncated towards zero
        pq = 17'($signed(pc_reg) >>> 15)
           + 17'((pc_reg[31] && (pc_reg[14:0] != 15'd0)) ? 1 : 0);
        vq = 17'($signed(vc_reg) >>> 15)
           + 17'((vc_reg[31] && (vc_reg[14:0] != 15'd0)) ? 1 : 0);
        psum = 18'(pq) + 18'($signed(boff_reg));
        held_inc = (held_reg < DEPTH_C) ? held_reg + CNT_W'(1) : held_reg;
    end

    // Sequencer and state update
    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        sidx_next   = sidx_reg;
        pt_next     = pt_reg;
        pc_next     = pc_reg;
        vt_next     = vt_reg;
        vc_next     = vc_reg;
        lvel_next   = lvel_reg;
        brange_next = brange_reg;
        boff_next   = boff_reg;
        coef_next   = coef_reg;
        porta_next  = porta_reg;
        damper_next = damper_reg;
        poly_next   = poly_reg;
        rleft_next  = rleft_reg;
        mod_next    = mod_reg;
        breath_next = breath_reg;
        at_next     = at_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        stk_cmd     = '0;
        stk_wr      = '{note: b1_reg, vel: b2_reg};
        mul_a       = '0;
        mul_b       = '0;
        s_tready    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_DECODE;
            end

            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (act_reg)
                    state_next = ST_GLIDE_P;
                else if (chan_reg == midi_chan_reg)
                begin
                    case (code_reg)
                        CIN_NOTE_OFF:
                        begin
                            sidx_next  = '0;
                            state_next = ST_SEARCH;
                        end
                        CIN_NOTE_ON:
                        begin
                            stk_cmd.push = 1'b1;
                            held_next = held_inc;
                            pt_next   = {1'b0, b1_reg, 24'd0};
                            vt_next   = {1'b0, b2_reg, 24'd0};
                            lvel_next = b2_reg;
                            if (!damper_reg)
                            begin
                                if (held_inc == CNT_W'(1))
                                begin
                                    pc_next = {1'b0, b1_reg, 24'd0};
                                    vc_next = {1'b0, b2_reg, 24'd0};
                                end
                                else if (retrig_en_reg && poly_reg)
                                begin
                                    pc_next    = {1'b0, b1_reg, 24'd0};
                                    vc_next    = {1'b0, b2_reg, 24'd0};
                                    rleft_next = RETRIG_LOAD;
                                end
                            end
                        end
                        CIN_CTRL:
                        begin
                            case (b1_reg)
                                CC_MOD_MSB:    mod_next = (mod_reg & LOW_KEEP) | {b2_reg, 9'd0};
                                CC_MOD_LSB:    mod_next = (mod_reg & HIGH_KEEP)
                                                        | {7'd0, b2_reg, 2'd0};
                                CC_BREATH_MSB: breath_next = (breath_reg & LOW_KEEP)
                                                           | {b2_reg, 9'd0};
                                CC_BREATH_LSB: breath_next = (breath_reg & HIGH_KEEP)
                                                           | {7'd0, b2_reg, 2'd0};
                                CC_BEND_RANGE: brange_next = {1'b0, b2_reg[6:1], 9'd0};
                                CC_PORTA_MSB:
                                begin
                                    porta_next = (porta_reg & LOW_KEEP) | {b2_reg, 9'd0};
                                    state_next = ST_PORTA_MUL;
                                end
                                CC_PORTA_LSB:
                                begin
                                    porta_next = (porta_reg & HIGH_KEEP)
                                               | {7'd0, b2_reg, 2'd0};
                                    state_next = ST_PORTA_MUL;
                                end
                                CC_DAMPER:
                                begin
                                    damper_next = (b2_reg != 7'd0);
                                    if ((b2_reg == 7'd0) && (held_reg == '0))
                                    begin
                                        lvel_next = '0;
                                        vt_next   = '0;
                                        vc_next   = '0;
                                    end
                                end
                                CC_SOUND_OFF, CC_NOTES_OFF:
                                begin
                                    damper_next = 1'b0;
                                    held_next   = '0;
                                    lvel_next   = '0;
                                    vt_next     = '0;
                                    vc_next     = '0;
                                end
                                CC_MONO: if (retrig_en_reg) poly_next = 1'b0;
                                CC_POLY: if (retrig_en_reg) poly_next = 1'b1;
                                default: ;
                            endcase
                        end
                        CIN_PRESSURE: at_next = {b1_reg, 9'd0};
                        CIN_BEND:     state_next = ST_BEND_MUL;
                        default: ;
                    endcase
                end
            end

            // Walk the stack one entry a cycle
            ST_SEARCH:
            begin
                if (sidx_reg >= held_reg)
                    state_next = ST_IDLE;
                else if (stk_rd_note == b1_reg)
                    state_next = ST_REMOVE;
                else
                    sidx_next = sidx_reg + CNT_W'(1);
            end

            ST_REMOVE:
            begin
                stk_cmd.remove = 1'b1;
                held_next  = held_reg - CNT_W'(1);
                state_next = ST_OFF_FIN;
            end

            ST_OFF_FIN:
            begin
                state_next = ST_IDLE;
                if (held_reg != '0)
                begin
                    pt_next = {1'b0, stk_top.note, 24'd0};
                    vt_next = {1'b0, stk_top.vel, 24'd0};
                    if (!damper_reg && retrig_en_reg && poly_reg)
                    begin
                        pc_next    = {1'b0, stk_top.note, 24'd0};
                        vc_next    = {1'b0, stk_top.vel, 24'd0};
                        rleft_next = RETRIG_LOAD;
                    end
                end
                else if (!damper_reg)
                begin
                    lvel_next = '0;
                    vt_next   = '0;
                    vc_next   = '0;
                end
            end

            ST_PORTA_MUL:
            begin
                mul_a      = $signed({2'b00, GLIDE_SCALE});
                mul_b      = $signed({1'b0, porta_reg});
                state_next = ST_PORTA_FIN;
            end

            ST_PORTA_FIN:
            begin
                coef_next  = exp_sum[15:0];
                state_next = ST_IDLE;
            end

            ST_BEND_MUL:
            begin
                mul_a      = $signed({2'b00, brange_reg});
                mul_b      = 17'($signed({1'b0, b2_reg, b1_reg} - BEND_CENTER));
                state_next = ST_BEND_FIN;
            end

            ST_BEND_FIN:
            begin
                boff_next  = bq[16:0];
                state_next = ST_IDLE;
            end

            // Glide pitch, then velocity, through the shared multiplier
            ST_GLIDE_P:
            begin
                mul_a      = 18'(gstep);
                mul_b      = $signed({1'b0, coef_reg});
                state_next = ST_GLIDE_V;
            end

            ST_GLIDE_V:
            begin
                pc_next    = pc_reg + mul_p[31:0];
                mul_a      = 18'(gstep);
                mul_b      = $signed({1'b0, coef_reg});
                state_next = ST_GLIDE_VW;
            end

            ST_GLIDE_VW:
            begin
                vc_next    = vc_reg + mul_p[31:0];
                state_next = ST_EMIT;
            end

            // Hold until the output register is free
            ST_EMIT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    if (psum < 0)
                        mdata_next[15:0] = '0;
                    else if (psum > 18'sd65535)
                        mdata_next[15:0] = 16'hFFFF;
                    else
                        mdata_next[15:0] = psum[15:0];
                    if (rleft_reg != 2'd0)
                    begin
                        rleft_next        = rleft_reg - 2'd1;
                        mdata_next[47:16] = '0;
                    end
                    else
                    begin
                        mdata_next[31:16] = vq[15:0];
                        mdata_next[47:32] = {lvel_reg, 9'd0};
                    end
                    mdata_next[63:48] = mod_reg;
                    mdata_next[79:64] = breath_reg;
                    mdata_next[95:80] = at_reg;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // State register and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            midi_chan_reg <= '0;
            retrig_en_reg <= 1'b0;
            held_reg      <= '0;
            sidx_reg      <= '0;
            pt_reg        <= '0;
            pc_reg        <= '0;
            vt_reg        <= '0;
            vc_reg        <= '0;
            lvel_reg      <= '0;
            brange_reg    <= BEND_RANGE_RST;
            boff_reg      <= '0;
            coef_reg      <= COEF_RST;
            porta_reg     <= '0;
            damper_reg    <= 1'b0;
            poly_reg      <= 1'b0;
            rleft_reg     <= '0;
            mod_reg       <= '0;
            breath_reg    <= '0;
            at_reg        <= '0;
            mvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            sidx_reg   <= sidx_next;
            pt_reg     <= pt_next;
            pc_reg     <= pc_next;
            vt_reg     <= vt_next;
            vc_reg     <= vc_next;
            lvel_reg   <= lvel_next;
            brange_reg <= brange_next;
            boff_reg   <= boff_next;
            coef_reg   <= coef_next;
            porta_reg  <= porta_next;
            damper_reg <= damper_next;
            poly_reg   <= poly_next;
            rleft_reg  <= rleft_next;
            mod_reg    <= mod_next;
            breath_reg <= breath_next;
            at_reg     <= at_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we)
            begin
                if (cfg_addr == CFG_CHANNEL)
                    midi_chan_reg <= cfg_data;
                else if (cfg_addr == CFG_RETRIG)
                    retrig_en_reg <= cfg_data[0];
            end
        end
    end

    // Latch the request and the result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg  <= s_tuser;
            code_reg <= s_tdata[3:0];
            chan_reg <= s_tdata[7:4];
            b1_reg   <= s_tdata[14:8];
            b2_reg   <= s_tdata[21:15];
        end
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    `include "midi_mono_cv_voice_macros.svh"

    `MCV_ASSERT_SAME(a_held_bound, 1'b1, held_reg <= DEPTH_C, "held count beyond stack depth")
    `MCV_ASSERT_SAME(a_coef_nonzero, 1'b1, coef_reg != 16'd0, "glide coefficient is zero")
    `MCV_ASSERT_SAME(a_pitch_sign, 1'b1, !pc_reg[31], "current pitch went negative")
    `MCV_ASSERT_NEXT(a_note_on_held,
        (state_reg == ST_DECODE) && !act_reg && (chan_reg == midi_chan_reg)
        && (code_reg == CIN_NOTE_ON),
        held_reg != '0, "note-on left the stack empty")
endmodule
